>>> rtl/fcbf_pkg.sv
// Shared types, sizes and request codes of the flow-controlled byte FIFO.
`default_nettype none
package fcbf_pkg;

    // Storage depth in bytes and the widths that follow from it.
    localparam int DEPTH  = 4096;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result.
    localparam int BYTE_W = 8;
    localparam int OFF_W  = 12;
    localparam int FLD_W  = 13;
    localparam int TOT_W  = 32;

    // Working width for comparing counts against the capacity register.
    localparam int WIDE_W = (CNT_W > FLD_W) ? CNT_W : FLD_W;

    localparam logic [FLD_W-1:0] CAP_RESET = FLD_W'(4096);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_POP   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_END   = 2'd3
    } req_code_t;

    typedef struct packed {
        req_code_t          req_type;
        logic [BYTE_W-1:0]  data_byte;
        logic [OFF_W-1:0]   peek_offset;
    } req_t;

    typedef struct packed {
        logic               accepted;
        logic [BYTE_W-1:0]  data_out;
        logic [FLD_W-1:0]   fill_count;
        logic [FLD_W-1:0]   space_left;
        logic [TOT_W-1:0]   total_written;
        logic [TOT_W-1:0]   total_read;
        logic               input_done;
        logic               at_eof;
    } rsp_t;

    // One access to the byte store per request.
    typedef struct packed {
        logic               we;
        logic               re;
        logic [PTR_W-1:0]   addr;
        logic [BYTE_W-1:0]  wdata;
    } mem_cmd_t;

endpackage
`default_nettype wire

>>> rtl/fcbf_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module fcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle; read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/fcbf_ctrl.sv
// Pointer, count and total bookkeeping of the byte FIFO, with store addressing.
`default_nettype none
module fcbf_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire fcbf_pkg::req_t              req,
    input  wire logic                        cfg_we,
    input  wire logic [fcbf_pkg::FLD_W-1:0]  cfg_wdata,
    output fcbf_pkg::mem_cmd_t               mem_cmd,
    output fcbf_pkg::rsp_t                   status,
    output logic                             rsp_valid,
    output logic                             rd_hit
);
    import fcbf_pkg::*;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOT_W-1:0]  wr_tot_reg, wr_tot_next;
    logic [TOT_W-1:0]  rd_tot_reg, rd_tot_next;
    logic              ended_reg, ended_next;
    logic [FLD_W-1:0]  cap_reg;
    logic              rsp_valid_reg;
    logic              rd_hit_reg, rd_hit_next;
    logic              acc_reg, acc_next;
    logic [FLD_W-1:0]  fill_reg, space_reg;

    logic [WIDE_W-1:0] cap_w, depth_w, eff_cap, count_w, off_w, count_after_w;
    logic [PTR_W-1:0]  off_p;
    logic [PTR_W:0]    peek_sum, peek_addr, tail_sum, tail_addr, head_inc;
    logic [WIDE_W-1:0] space_w;

    // Effective capacity is the register clipped to the store depth.
    always_comb
    begin
        cap_w   = WIDE_W'(cap_reg);
        depth_w = WIDE_W'(DEPTH);
        eff_cap = (cap_w > depth_w) ? depth_w : cap_w;
        count_w = WIDE_W'(count_reg);
        off_w   = WIDE_W'(req.peek_offset);
        off_p   = off_w[PTR_W-1:0];
    end

    // Store addresses: head plus an offset, wrapped once at the depth.
    always_comb
    begin
        peek_sum  = {1'b0, head_reg} + {1'b0, off_p};
        peek_addr = (peek_sum >= (PTR_W+1)'(DEPTH)) ? peek_sum - (PTR_W+1)'(DEPTH) : peek_sum;
        tail_sum  = {1'b0, head_reg} + {1'b0, count_reg[PTR_W-1:0]};
        tail_addr = (tail_sum >= (PTR_W+1)'(DEPTH)) ? tail_sum - (PTR_W+1)'(DEPTH) : tail_sum;
        head_inc  = {1'b0, head_reg} + (PTR_W+1)'(1);
        if (head_inc >= (PTR_W+1)'(DEPTH))
        begin
            head_inc = '0;
        end
    end

    // Request decode: next state and the one store access it needs.
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        wr_tot_next   = wr_tot_reg;
        rd_tot_next   = rd_tot_reg;
        ended_next    = ended_reg;
        acc_next      = 1'b0;
        rd_hit_next   = 1'b0;
        mem_cmd.we    = 1'b0;
        mem_cmd.re    = 1'b0;
        mem_cmd.addr  = tail_addr[PTR_W-1:0];
        mem_cmd.wdata = req.data_byte;
        if (take)
        begin
            case (req.req_type)
                REQ_WRITE:
                begin
                    if (count_w < eff_cap)
                    begin
                        mem_cmd.we  = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        wr_tot_next = wr_tot_reg + TOT_W'(1);
                        acc_next    = 1'b1;
                    end
                end
                REQ_POP:
                begin
                    mem_cmd.addr = head_reg;
                    if (count_reg != '0)
                    begin
                        mem_cmd.re  = 1'b1;
                        head_next   = head_inc[PTR_W-1:0];
                        count_next  = count_reg - CNT_W'(1);
                        rd_tot_next = rd_tot_reg + TOT_W'(1);
                        acc_next    = 1'b1;
                        rd_hit_next = 1'b1;
                    end
                end
                REQ_PEEK:
                begin
                    mem_cmd.addr = peek_addr[PTR_W-1:0];
                    if (off_w < count_w)
                    begin
                        mem_cmd.re  = 1'b1;
                        acc_next    = 1'b1;
                        rd_hit_next = 1'b1;
                    end
                end
                REQ_END:
                begin
                    ended_next = 1'b1;
                end
                default:
                begin
                    ended_next = ended_reg;
                end
            endcase
        end
        count_after_w = WIDE_W'(count_next);
        space_w       = (count_after_w < eff_cap) ? eff_cap - count_after_w : '0;
    end

    // Control state and capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            wr_tot_reg    <= '0;
            rd_tot_reg    <= '0;
            ended_reg     <= 1'b0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            wr_tot_reg    <= wr_tot_next;
            rd_tot_reg    <= rd_tot_next;
            ended_reg     <= ended_next;
            rsp_valid_reg <= take;
            rd_hit_reg    <= rd_hit_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Result payload captured with the request.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            acc_reg   <= acc_next;
            fill_reg  <= count_after_w[FLD_W-1:0];
            space_reg <= space_w[FLD_W-1:0];
        end
    end

    always_comb
    begin
        status.accepted      = acc_reg;
        status.data_out      = '0;
        status.fill_count    = fill_reg;
        status.space_left    = space_reg;
        status.total_written = wr_tot_reg;
        status.total_read    = rd_tot_reg;
        status.input_done    = ended_reg;
        status.at_eof        = ended_reg && (count_reg == '0);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rd_hit    = rd_hit_reg;

    // The fill level never passes the store depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WIDE_W'(count_reg) <= WIDE_W'(DEPTH))
        else $error("fill level above store depth");

    // A store access is either a write or a read, never both.
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.we && mem_cmd.re))
        else $error("write and read issued together");

    // A stored byte raises the fill level by one.
    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.we |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("write did not advance the fill level");

    // Every request yields a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rsp_valid)
        else $error("request without a result");

    // A byte returned is always a request that was accepted.
    a_hit_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rd_hit |-> (rsp_valid && acc_reg))
        else $error("read data without an accepted request");

endmodule
`default_nettype wire

>>> rtl/flow_controlled_byte_fifo.sv
// Top level of the flow-controlled byte FIFO: bookkeeping, byte store and result assembly.
// The result of a request shows on rsp in the cycle after start is taken.
// Throughput: one request per cycle; busy stays low, set by the single store port.
// The result strobe rsp_valid lasts one cycle, and the receiver cannot stall it.
// Reset clears pointers, fill level, totals and the ended flag; capacity returns to 4096.
// The byte store is not cleared: only held bytes are ever read.
`default_nettype none
module flow_controlled_byte_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire fcbf_pkg::req_t              req,
    input  wire logic                        cfg_we,
    input  wire logic [fcbf_pkg::FLD_W-1:0]  cfg_wdata,
    output logic                             rsp_valid,
    output fcbf_pkg::rsp_t                   rsp
);
    import fcbf_pkg::*;

    mem_cmd_t          mem_cmd;
    rsp_t              status;
    logic              rd_hit;
    logic [BYTE_W-1:0] rdata;
    logic              take;

    // One request per cycle; the store port is free every cycle.
    assign busy = 1'b0;
    assign take = start && !busy;

    fcbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_cmd   (mem_cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rd_hit    (rd_hit)
    );

    fcbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_cmd.we),
        .re    (mem_cmd.re),
        .addr  (mem_cmd.addr),
        .wdata (mem_cmd.wdata),
        .rdata (rdata)
    );

    // Merge the store read data into the result; zero when nothing was found.
    always_comb
    begin
        rsp          = status;
        rsp.data_out = rd_hit ? rdata : '0;
    end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flow-controlled byte FIFO: directed, random and bulk passes.
module tb_top;
    import fcbf_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 310;
    localparam int BULK_FILL    = 320;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE       = 3;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             cfg_we;
    logic [FLD_W-1:0] cfg_wdata;
    logic             rsp_valid;
    rsp_t             rsp;

    flow_controlled_byte_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mirror of the FIFO contents and bookkeeping.
    logic [BYTE_W-1:0] mirror_mem [DEPTH];
    int unsigned       mirror_head;
    int unsigned       mirror_fill;
    logic [TOT_W-1:0]  mirror_written;
    logic [TOT_W-1:0]  mirror_read;
    logic              mirror_ended;
    logic [FLD_W-1:0]  mirror_cap;

    // Responses awaited from the block, oldest first.
    rsp_t pending_rsp [$];

    // A directed row may carry a hand-typed response that replaces the mirror's.
    logic row_typed;
    rsp_t row_expect;

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned req_by_code [4];
    int unsigned refused_writes;
    int unsigned empty_pops;
    int unsigned missed_peeks;
    int unsigned eof_responses;
    int unsigned peak_fill;

    typedef struct packed {
        logic             is_cfg;
        logic [FLD_W-1:0] cap_value;
        req_t             rq;
        logic             typed;
        rsp_t             want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // Applies one request to the mirror and returns the response it should give.
    task automatic fifo_predict(input req_t r, output rsp_t o);
        int unsigned eff_cap;
        int unsigned slot;
        o = '0;
        eff_cap = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
        case (r.req_type)
            REQ_WRITE:
            begin
                if (mirror_fill < eff_cap)
                begin
                    slot = (mirror_head + mirror_fill) % DEPTH;
                    mirror_mem[slot] = r.data_byte;
                    mirror_fill++;
                    mirror_written++;
                    o.accepted = 1'b1;
                end
            end
            REQ_POP:
            begin
                if (mirror_fill > 0)
                begin
                    o.data_out = mirror_mem[mirror_head];
                    mirror_head = (mirror_head + 1) % DEPTH;
                    mirror_fill--;
                    mirror_read++;
                    o.accepted = 1'b1;
                end
            end
            REQ_PEEK:
            begin
                if (r.peek_offset < mirror_fill)
                begin
                    slot = (mirror_head + r.peek_offset) % DEPTH;
                    o.data_out = mirror_mem[slot];
                    o.accepted = 1'b1;
                end
            end
            default:
            begin
                mirror_ended = 1'b1;
            end
        endcase
        o.fill_count    = FLD_W'(mirror_fill);
        o.space_left    = (mirror_fill < eff_cap) ? FLD_W'(eff_cap - mirror_fill) : '0;
        o.total_written = mirror_written;
        o.total_read    = mirror_read;
        o.input_done    = mirror_ended;
        o.at_eof        = mirror_ended && (mirror_fill == 0);
    endtask

    // Compares one response from the block with the oldest one awaited.
    task automatic check_response(input rsp_t got);
        rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR %0t: response with no request outstanding", $realtime);
            return;
        end
        want = pending_rsp.pop_front();
        results_checked++;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("ERROR %0t: response %0d, expected/actual:", $realtime, results_checked);
                $display("  accepted %0b/%0b data_out %02h/%02h fill %0d/%0d space %0d/%0d",
                         want.accepted, got.accepted, want.data_out, got.data_out,
                         want.fill_count, got.fill_count, want.space_left, got.space_left);
                $display("  written %0d/%0d read %0d/%0d done %0b/%0b eof %0b/%0b",
                         want.total_written, got.total_written, want.total_read,
                         got.total_read, want.input_done, got.input_done,
                         want.at_eof, got.at_eof);
            end
        end
    endtask

    // Watches the ports: checks responses, tracks capacity writes, predicts requests.
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t predicted;
        if (!rst_n)
        begin
            mirror_head    = 0;
            mirror_fill    = 0;
            mirror_written = '0;
            mirror_read    = '0;
            mirror_ended   = 1'b0;
            mirror_cap     = CAP_RESET;
            pending_rsp.delete();
        end
        else
        begin
            if (rsp_valid)
                check_response(rsp);
            if (cfg_we)
                mirror_cap = cfg_wdata;
            if (start && !busy)
            begin
                fifo_predict(req, predicted);
                pending_rsp.push_back(row_typed ? row_expect : predicted);
                req_by_code[int'(req.req_type)]++;
                if (req.req_type == REQ_WRITE && !predicted.accepted)
                    refused_writes++;
                if (req.req_type == REQ_POP && !predicted.accepted)
                    empty_pops++;
                if (req.req_type == REQ_PEEK && !predicted.accepted)
                    missed_peeks++;
                if (predicted.at_eof)
                    eof_responses++;
                if (mirror_fill > peak_fill)
                    peak_fill = mirror_fill;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic req_t make_req(input req_code_t code, input int data, input int offset);
        req_t r;
        r.req_type    = code;
        r.data_byte   = BYTE_W'(data);
        r.peek_offset = OFF_W'(offset);
        return r;
    endfunction

    function automatic rsp_t rsp_of(input logic acc, input int fill, input int space,
                                    input int wr, input int rd, input logic done,
                                    input logic eof);
        rsp_t o;
        o               = '0;
        o.accepted      = acc;
        o.fill_count    = FLD_W'(fill);
        o.space_left    = FLD_W'(space);
        o.total_written = TOT_W'(wr);
        o.total_read    = TOT_W'(rd);
        o.input_done    = done;
        o.at_eof        = eof;
        return o;
    endfunction

    function automatic dir_row_t req_row(input req_code_t code, input int data, input int offset);
        dir_row_t row;
        row    = '0;
        row.rq = make_req(code, data, offset);
        return row;
    endfunction

    function automatic dir_row_t typed_row(input req_code_t code, input int data,
                                           input int offset, input rsp_t want);
        dir_row_t row;
        row       = req_row(code, data, offset);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic dir_row_t cap_row(input int value);
        dir_row_t row;
        row           = '0;
        row.is_cfg    = 1'b1;
        row.cap_value = FLD_W'(value);
        return row;
    endfunction

    // Random request: mostly writes and pops, peeks mostly inside the held bytes.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        r.data_byte   = BYTE_W'($urandom);
        r.peek_offset = OFF_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 44)
            r.req_type = REQ_WRITE;
        else if (pick < 84)
            r.req_type = REQ_POP;
        else if (pick < 97)
        begin
            r.req_type = REQ_PEEK;
            if ($urandom_range(0, 7) == 0)
                r.peek_offset = OFF_W'(mirror_fill);
            else if (mirror_fill > 0 && $urandom_range(0, 3) != 0)
                r.peek_offset = OFF_W'($urandom_range(0, mirror_fill - 1));
        end
        else
            r.req_type = REQ_END;
        return r;
    endfunction

    // All driving tasks start and end at a falling edge.
    task automatic send_request(input req_t r, input logic typed, input rsp_t want);
        start      <= 1'b1;
        req        <= r;
        row_typed  <= typed;
        row_expect <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Leaves start low in each cycle with the given chance in percent.
    task automatic sender_gap(input int pct);
        while ($urandom_range(1, 100) <= pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Holds off new requests until every awaited response has come.
    task automatic drain_responses();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input int value);
        drain_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= FLD_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int phase_caps [4];
        int phase_gaps [4];
        start      = 1'b0;
        req        = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        row_typed  = 1'b0;
        row_expect = '0;
        rst_n      = 1'b0;

        // Directed table: empty FIFO, data extremes, end flag, capacity corners.
        dir_rows.push_back(typed_row(REQ_POP,   8'h00, 0,    rsp_of(0, 0, 4096, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(REQ_PEEK,  8'h00, 0,    rsp_of(0, 0, 4096, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(REQ_PEEK,  8'hFF, 4095, rsp_of(0, 0, 4096, 0, 0, 0, 0)));
        dir_rows.push_back(typed_row(REQ_WRITE, 8'h00, 0,    rsp_of(1, 1, 4095, 1, 0, 0, 0)));
        dir_rows.push_back(typed_row(REQ_WRITE, 8'hFF, 4095, rsp_of(1, 2, 4094, 2, 0, 0, 0)));
        dir_rows.push_back(req_row(REQ_PEEK,  8'h00, 1));
        dir_rows.push_back(req_row(REQ_PEEK,  8'h00, 2));
        dir_rows.push_back(typed_row(REQ_POP,   8'h00, 0,    rsp_of(1, 1, 4095, 2, 1, 0, 0)));
        dir_rows.push_back(typed_row(REQ_END,   8'hFF, 0,    rsp_of(0, 1, 4095, 2, 1, 1, 0)));
        dir_rows.push_back(typed_row(REQ_END,   8'h00, 0,    rsp_of(0, 1, 4095, 2, 1, 1, 0)));
        dir_rows.push_back(req_row(REQ_WRITE, 8'hA5, 0));
        dir_rows.push_back(req_row(REQ_POP,   8'h00, 0));
        dir_rows.push_back(req_row(REQ_POP,   8'h00, 0));
        dir_rows.push_back(typed_row(REQ_POP,   8'h00, 0,    rsp_of(0, 0, 4096, 3, 3, 1, 1)));
        dir_rows.push_back(cap_row(0));
        dir_rows.push_back(typed_row(REQ_WRITE, 8'h3C, 0,    rsp_of(0, 0, 0, 3, 3, 1, 1)));
        dir_rows.push_back(cap_row(8191));
        dir_rows.push_back(req_row(REQ_WRITE, 8'h81, 0));
        dir_rows.push_back(req_row(REQ_WRITE, 8'h7E, 0));
        dir_rows.push_back(req_row(REQ_WRITE, 8'h55, 0));
        dir_rows.push_back(req_row(REQ_PEEK,  8'h00, 4095));
        // Capacity dropped below the fill: bytes stay, writes are refused.
        dir_rows.push_back(cap_row(1));
        dir_rows.push_back(typed_row(REQ_WRITE, 8'h12, 0,    rsp_of(0, 3, 0, 6, 3, 1, 0)));
        dir_rows.push_back(req_row(REQ_POP,   8'h00, 0));
        dir_rows.push_back(req_row(REQ_POP,   8'h00, 0));
        dir_rows.push_back(req_row(REQ_POP,   8'h00, 0));
        dir_rows.push_back(req_row(REQ_WRITE, 8'h00, 0));
        dir_rows.push_back(req_row(REQ_WRITE, 8'hFF, 0));

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_capacity(dir_rows[i].cap_value);
            else
                send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each under its own capacity and sender idle rate.
        phase_caps = '{4, 1, 16, $urandom_range(2, 300)};
        phase_gaps = '{0, 85, 0, 10};
        for (int p = 0; p < 4; p++)
        begin
            write_capacity(phase_caps[p]);
            repeat (PHASE_ITEMS)
            begin
                sender_gap(phase_gaps[p]);
                send_request(random_request(), 1'b0, '0);
            end
        end

        // Bulk pass: fill well above the phase capacities, then drain to empty.
        write_capacity(4096);
        while (mirror_fill < BULK_FILL)
            send_request(make_req(REQ_WRITE, $urandom, $urandom), 1'b0, '0);
        send_request(make_req(REQ_PEEK, 0, BULK_FILL - 1), 1'b0, '0);
        send_request(make_req(REQ_PEEK, 0, 4095), 1'b0, '0);
        while (mirror_fill > 0)
        begin
            case ($urandom_range(0, 15))
                0:       send_request(make_req(REQ_WRITE, $urandom, 0), 1'b0, '0);
                1:       send_request(make_req(REQ_PEEK, 0, $urandom_range(0, BULK_FILL)),
                                      1'b0, '0);
                default: send_request(make_req(REQ_POP, 0, 0), 1'b0, '0);
            endcase
        end
        send_request(make_req(REQ_POP, 0, 0), 1'b0, '0);

        drain_responses();
        if (pending_rsp.size() != 0)
            mismatches += pending_rsp.size();

        $display("Ran %0d wr (%0d refused) %0d pop (%0d empty) %0d peek (%0d miss) %0d end",
                 req_by_code[int'(REQ_WRITE)], refused_writes, req_by_code[int'(REQ_POP)],
                 empty_pops, req_by_code[int'(REQ_PEEK)], missed_peeks,
                 req_by_code[int'(REQ_END)]);
        $display("Checked %0d results, %0d at eof, peak fill %0d, %0d mismatches",
                 results_checked, eof_responses, peak_fill, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/fcbf_pkg.sv
rtl/fcbf_ram.sv
rtl/fcbf_ctrl.sv
rtl/flow_controlled_byte_fifo.sv
tb/tb_top.sv
